// ===== rtl/rtf_pkg.sv =====
// Shared types, constants and table functions for the rotozoom texel fetch core.
`timescale 1ns / 1ps

package rtf_pkg;

   localparam int TEXTURE_SIDE = 128;
   localparam int DISPLAY_W    = 320;
   localparam int DISPLAY_H    = 240;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RENDER  = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP = 2'd2;

   localparam logic [8:0] ANGLE_STEP_RESET = 9'd2;

   localparam int TEXEL_W = 24;
   localparam int TRIG_W  = 16;   // Q1.14 sine/cosine, signed
   localparam int COORD_W = 11;   // magnitude of scaled texture coordinate
   localparam int RAW_W   = 16;   // row*width+column before folding into the store
   localparam int Q_W     = 13;   // |P*s*6| >> 28
   localparam int SCALE_SHIFT = 28;
   localparam int FIVE_SHIFT  = 18;
   localparam logic [15:0] RECIP_FIVE = 16'd52429;   // ceil(2^18/5), exact below 2^18

   typedef struct packed {
      logic [1:0]         operation;
      logic [13:0]        texel_index;
      logic [TEXEL_W-1:0] texel_rgb;
      logic [8:0]         pixel_x;
      logic [8:0]         pixel_y;
   } req_type;

   typedef struct packed {
      logic [8:0]         out_x;
      logic [8:0]         out_y;
      logic [TEXEL_W-1:0] color;
   } rsp_type;

   // what an item carries down the pipe besides the arithmetic
   typedef struct packed {
      logic               is_load;
      logic [8:0]         pixel_x;
      logic [8:0]         pixel_y;
      logic [13:0]        texel_index;
      logic [TEXEL_W-1:0] texel_rgb;
   } side_type;

   // texture size with zero already mapped to one
   typedef struct packed {
      logic [7:0] tex_w;
      logic [7:0] tex_h;
   } div_type;

   typedef struct packed {
      side_type           side;
      logic               neg_v;
      logic [COORD_W-1:0] mag_u;
      logic [COORD_W-1:0] mag_v;
   } coord_type;

   typedef struct packed {
      side_type   side;
      logic       neg_v;
      logic [7:0] rem_u;
      logic [7:0] rem_v;
   } remd_type;

   localparam logic [14:0] QUARTER_SINE [91] = '{
          15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,
       15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
       15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
       15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
       15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
       15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
       15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
       15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
      15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
      15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
      15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
      15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
      15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
      15'd16384
   };

   // full-wave sine from the quarter table, deg below 360
   function automatic logic signed [TRIG_W-1:0] rtf_sine(input logic [8:0] deg);
      logic [8:0]        idx;
      logic              neg;
      logic [TRIG_W-1:0] mag;
      if (deg <= 9'd90) begin
         idx = deg;
         neg = 1'b0;
      end else if (deg <= 9'd180) begin
         idx = 9'd180 - deg;
         neg = 1'b0;
      end else if (deg <= 9'd270) begin
         idx = deg - 9'd180;
         neg = 1'b1;
      end else begin
         idx = 9'd360 - deg;
         neg = 1'b1;
      end
      mag = {1'b0, QUARTER_SINE[idx[6:0]]};
      return neg ? $signed(-mag) : $signed(mag);
   endfunction

   // angle of the cosine: deg + 90 modulo 360
   function automatic logic [8:0] rtf_cos_deg(input logic [8:0] deg);
      return (deg >= 9'd270) ? deg - 9'd270 : deg + 9'd90;
   endfunction

   // one restoring step of an unsigned remainder
   function automatic logic [7:0] rtf_rem_step(input logic [7:0] rem, input logic bit_in,
                                               input logic [7:0] div);
      logic [8:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, div}) t = t - {1'b0, div};
      return t[7:0];
   endfunction

endpackage

// ===== rtl/rtf_coord_unit.sv =====
// Rotate and zoom pipeline: screen coordinate to signed texture coordinate magnitudes.
`timescale 1ns / 1ps

module rtf_coord_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rtf_pkg::side_type   in_side,
   input  logic [8:0]          angle,
   output logic                out_valid,
   input  logic                out_ready,
   output rtf_pkg::coord_type  out_data
);

   localparam int NS     = 6;
   localparam int TW     = rtf_pkg::TRIG_W;
   localparam int PROD_W = 26;
   localparam int MUL_W  = 40;
   localparam int CW     = rtf_pkg::COORD_W;
   localparam int QW     = rtf_pkg::Q_W;
   localparam int FIVE_W = QW + 16;

   logic [NS-1:0]    vld_ff;
   logic [NS:0]      go;
   rtf_pkg::side_type side_ff [NS];

   logic signed [TW-1:0]     sin0_ff, cos0_ff, sin1_ff, sin2_ff;
   logic signed [PROD_W-1:0] xc1_ff, ys1_ff, xs1_ff, yc1_ff;
   logic signed [PROD_W-1:0] xc1_in, ys1_in, xs1_in, yc1_in;
   logic signed [PROD_W-1:0] pu2_ff, pv2_ff, pu2_in, pv2_in;
   logic signed [MUL_W-1:0]  mu3_ff, mv3_ff, mu3_in, mv3_in;
   logic [QW-1:0]            qu4_ff, qv4_ff, qu4_in, qv4_in;
   logic                     negv4_ff, negv5_ff;
   logic [CW-1:0]            tu5_ff, tv5_ff, tu5_in, tv5_in;

   logic signed [9:0]  x0, y0;
   logic [MUL_W-1:0]   mag_u, mag_v;
   logic [MUL_W+1:0]   six_u, six_v;
   logic [FIVE_W-1:0]  fu, fv;

   // a stage may load when it is empty or its item moves on
   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !vld_ff[k] || go[k+1];
   end

   assign in_ready  = go[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (go[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      x0 = $signed({1'b0, side_ff[0].pixel_x});
      y0 = $signed({1'b0, side_ff[0].pixel_y});
      xc1_in = PROD_W'(x0) * PROD_W'(cos0_ff);
      ys1_in = PROD_W'(y0) * PROD_W'(sin0_ff);
      xs1_in = PROD_W'(x0) * PROD_W'(sin0_ff);
      yc1_in = PROD_W'(y0) * PROD_W'(cos0_ff);

      pu2_in = xc1_ff - ys1_ff;
      pv2_in = xs1_ff + yc1_ff;

      mu3_in = MUL_W'(pu2_ff) * MUL_W'(sin2_ff);
      mv3_in = MUL_W'(pv2_ff) * MUL_W'(sin2_ff);

      // |P*s| * 6, then the 2^28 part of the divisor
      mag_u  = mu3_ff[MUL_W-1] ? $unsigned(-mu3_ff) : $unsigned(mu3_ff);
      mag_v  = mv3_ff[MUL_W-1] ? $unsigned(-mv3_ff) : $unsigned(mv3_ff);
      six_u  = {mag_u, 2'b00} + {1'b0, mag_u, 1'b0};
      six_v  = {mag_v, 2'b00} + {1'b0, mag_v, 1'b0};
      qu4_in = six_u[rtf_pkg::SCALE_SHIFT +: QW];
      qv4_in = six_v[rtf_pkg::SCALE_SHIFT +: QW];

      // divide by 5 through the reciprocal
      fu     = FIVE_W'(qu4_ff) * FIVE_W'(rtf_pkg::RECIP_FIVE);
      fv     = FIVE_W'(qv4_ff) * FIVE_W'(rtf_pkg::RECIP_FIVE);
      tu5_in = fu[rtf_pkg::FIVE_SHIFT +: CW];
      tv5_in = fv[rtf_pkg::FIVE_SHIFT +: CW];
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         side_ff[0] <= in_side;
         sin0_ff    <= rtf_pkg::rtf_sine(angle);
         cos0_ff    <= rtf_pkg::rtf_sine(rtf_pkg::rtf_cos_deg(angle));
      end
      for (int k = 1; k < NS; k++) begin
         if (go[k]) side_ff[k] <= side_ff[k-1];
      end
      if (go[1]) begin
         sin1_ff <= sin0_ff;
         xc1_ff  <= xc1_in;
         ys1_ff  <= ys1_in;
         xs1_ff  <= xs1_in;
         yc1_ff  <= yc1_in;
      end
      if (go[2]) begin
         sin2_ff <= sin1_ff;
         pu2_ff  <= pu2_in;
         pv2_ff  <= pv2_in;
      end
      if (go[3]) begin
         mu3_ff <= mu3_in;
         mv3_ff <= mv3_in;
      end
      if (go[4]) begin
         negv4_ff <= mv3_ff[MUL_W-1];
         qu4_ff   <= qu4_in;
         qv4_ff   <= qv4_in;
      end
      if (go[5]) begin
         negv5_ff <= negv4_ff;
         tu5_ff   <= tu5_in;
         tv5_ff   <= tv5_in;
      end
   end

   assign out_data.side  = side_ff[NS-1];
   assign out_data.neg_v = negv5_ff;
   assign out_data.mag_u = tu5_ff;
   assign out_data.mag_v = tv5_ff;

endmodule

// ===== rtl/rtf_rem_unit.sv =====
// Pipelined restoring remainder of the coordinate magnitudes by texture width and height.
`timescale 1ns / 1ps

module rtf_rem_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rtf_pkg::coord_type in_data,
   input  rtf_pkg::div_type   div,
   output logic               out_valid,
   input  logic               out_ready,
   output rtf_pkg::remd_type  out_data
);

   localparam int CW    = rtf_pkg::COORD_W;
   localparam int STEPS = 3;                       // dividend bits per stage
   localparam int NS    = (CW + STEPS - 1) / STEPS;

   logic [NS-1:0]     vld_ff;
   logic [NS:0]       go;
   rtf_pkg::side_type side_ff [NS];
   logic [NS-1:0]     negv_ff;
   logic [7:0]        ru_ff [NS], rv_ff [NS], ru_in [NS], rv_in [NS];
   logic [CW-1:0]     du_ff [NS], dv_ff [NS], du_in [NS], dv_in [NS];

   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !vld_ff[k] || go[k+1];
   end

   assign in_ready  = go[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (go[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // dividend shifts out MSB first; the last stage may take fewer bits
   always_comb begin
      logic [7:0]    r_u, r_v;
      logic [CW-1:0] d_u, d_v;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            r_u = '0;
            r_v = '0;
            d_u = in_data.mag_u;
            d_v = in_data.mag_v;
         end else begin
            r_u = ru_ff[k-1];
            r_v = rv_ff[k-1];
            d_u = du_ff[k-1];
            d_v = dv_ff[k-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < CW) begin
               r_u = rtf_pkg::rtf_rem_step(r_u, d_u[CW-1], div.tex_w);
               r_v = rtf_pkg::rtf_rem_step(r_v, d_v[CW-1], div.tex_h);
               d_u = {d_u[CW-2:0], 1'b0};
               d_v = {d_v[CW-2:0], 1'b0};
            end
         end
         ru_in[k] = r_u;
         rv_in[k] = r_v;
         du_in[k] = d_u;
         dv_in[k] = d_v;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (go[k]) begin
            side_ff[k] <= (k == 0) ? in_data.side  : side_ff[k-1];
            negv_ff[k] <= (k == 0) ? in_data.neg_v : negv_ff[k-1];
            ru_ff[k]   <= ru_in[k];
            rv_ff[k]   <= rv_in[k];
            du_ff[k]   <= du_in[k];
            dv_ff[k]   <= dv_in[k];
         end
      end
   end

   assign out_data.side  = side_ff[NS-1];
   assign out_data.neg_v = negv_ff[NS-1];
   assign out_data.rem_u = ru_ff[NS-1];
   assign out_data.rem_v = rv_ff[NS-1];

endmodule

// ===== rtl/rtf_texel_mem.sv =====
// Texel address folding, texture store and registered result stage.
`timescale 1ns / 1ps

module rtf_texel_mem #(
   parameter int TEXTURE_SIDE = rtf_pkg::TEXTURE_SIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rtf_pkg::remd_type in_data,
   input  rtf_pkg::div_type  div,
   output logic              out_valid,
   input  logic              out_ready,
   output rtf_pkg::rsp_type  out_data
);

   localparam int DEPTH  = TEXTURE_SIDE * TEXTURE_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = rtf_pkg::RAW_W;
   localparam int XW     = rtf_pkg::TEXEL_W;
   localparam int QW     = $clog2((1 << RW) / DEPTH + 1);
   localparam int PROD_W = 32 + QW;
   localparam longint unsigned RECIP = (64'd1 << 32) / DEPTH;   // floor(2^32 / DEPTH)
   localparam int NS     = 4;

   logic [NS-1:0]     vld_ff;
   logic [NS:0]       go;
   rtf_pkg::side_type side_ff [NS-1];

   logic [RW-1:0]     raw0_ff, raw0_in, raw1_ff;
   logic [QW-1:0]     q1_ff, q1_in;
   logic [AW-1:0]     addr2_ff, addr2_in;
   logic [7:0]        v_fix;
   logic [PROD_W-1:0] prod;
   logic [RW-1:0]     diff;
   logic              mem_go;

   logic [XW-1:0]     store_mem [DEPTH];
   logic [XW-1:0]     rdata_ff;
   logic [8:0]        out_x_ff, out_y_ff;

   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !vld_ff[k] || go[k+1];
   end

   assign in_ready  = go[0];
   assign out_valid = vld_ff[NS-1];

   // loads retire at the store; only renders reach the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[0]) vld_ff[0] <= in_valid;
         if (go[1]) vld_ff[1] <= vld_ff[0];
         if (go[2]) vld_ff[2] <= vld_ff[1];
         if (go[3]) vld_ff[3] <= vld_ff[2] && !side_ff[2].is_load;
      end
   end

   always_comb begin
      // negative v wraps: h - r, unless the remainder is zero
      v_fix = (in_data.neg_v && (in_data.rem_v != 8'd0)) ? div.tex_h - in_data.rem_v
                                                          : in_data.rem_v;
      if (in_data.side.is_load) begin
         raw0_in = RW'(in_data.side.texel_index);
      end else begin
         raw0_in = RW'(v_fix) * RW'(div.tex_w) + RW'(in_data.rem_u);
      end

      // fold into the store depth: reciprocal estimate is low by at most one
      prod  = PROD_W'(raw0_ff) * PROD_W'(RECIP);
      q1_in = prod[32 +: QW];

      diff = raw1_ff - RW'(q1_ff * DEPTH);
      if (diff >= RW'(DEPTH)) addr2_in = AW'(diff - RW'(DEPTH));
      else                    addr2_in = AW'(diff);
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         side_ff[0] <= in_data.side;
         raw0_ff    <= raw0_in;
      end
      if (go[1]) begin
         side_ff[1] <= side_ff[0];
         raw1_ff    <= raw0_ff;
         q1_ff      <= q1_in;
      end
      if (go[2]) begin
         side_ff[2] <= side_ff[1];
         addr2_ff   <= addr2_in;
      end
      if (go[3]) begin
         out_x_ff <= side_ff[2].pixel_x;
         out_y_ff <= side_ff[2].pixel_y;
      end
   end

   // one access per cycle, in item order, so a read always sees earlier loads
   assign mem_go = vld_ff[2] && go[3];

   always_ff @(posedge clock) begin
      if (mem_go) begin
         if (side_ff[2].is_load) store_mem[addr2_ff] <= side_ff[2].texel_rgb;
         else                    rdata_ff <= store_mem[addr2_ff];
      end
   end

   assign out_data.out_x = out_x_ff;
   assign out_data.out_y = out_y_ff;
   assign out_data.color = rdata_ff;

endmodule

// ===== rtl/rotozoom_texel_fetch_core.sv =====
// Top level of the rotozoom texel fetch core: control registers, angle and pipeline.
`timescale 1ns / 1ps

// Takes one item per clock and returns a result for each on-screen render it
// accepts, sustaining one item per clock while rsp_ready stays high. The
// pipeline is elastic: a full stage holds while its successor stalls, so empty
// stages keep filling while a result waits. Stages: sine/cosine lookup, the
// rotation products, the zoom product, the divide by 5*2^28 (shift and
// reciprocal), a four-stage restoring remainder by width and height (three
// bits per stage), row*width+column, the fold into the store depth, and one
// access to the single-port texture memory. Loads travel the same pipe and
// write at that memory stage, so loads and renders reach the store in the
// order they were accepted. Advance items, unknown operations and off-screen
// renders retire at acceptance. The store holds TEXTURE_SIDE^2 texels and is
// not cleared; a render of a texel never loaded returns an undefined color.

module rotozoom_texel_fetch_core #(
   parameter int TEXTURE_SIDE = rtf_pkg::TEXTURE_SIDE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rtf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rtf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rtf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [7:0]  tex_width_ff, tex_height_ff;
   logic [8:0]  angle_step_ff;
   logic [8:0]  angle_ff, angle_in;
   logic [9:0]  angle_sum;

   logic               req_acc, is_load, is_render;
   rtf_pkg::side_type  in_side;
   rtf_pkg::div_type   div;
   logic               c_valid, c_ready, r_valid, r_ready;
   rtf_pkg::coord_type c_data;
   rtf_pkg::remd_type  r_data;

   assign req_acc   = req_valid && req_ready;
   assign is_load   = req_data.operation == rtf_pkg::OP_LOAD;
   assign is_render = (req_data.operation == rtf_pkg::OP_RENDER)
                      && (32'(req_data.pixel_x) < rtf_pkg::DISPLAY_W)
                      && (32'(req_data.pixel_y) < rtf_pkg::DISPLAY_H);

   assign in_side.is_load     = is_load;
   assign in_side.pixel_x     = req_data.pixel_x;
   assign in_side.pixel_y     = req_data.pixel_y;
   assign in_side.texel_index = req_data.texel_index;
   assign in_side.texel_rgb   = req_data.texel_rgb;

   assign div.tex_w = (tex_width_ff  == 8'd0) ? 8'd1 : tex_width_ff;
   assign div.tex_h = (tex_height_ff == 8'd0) ? 8'd1 : tex_height_ff;

   // angle below 360 plus a step up to 511: at most two wraps
   always_comb begin
      angle_sum = {1'b0, angle_ff} + {1'b0, angle_step_ff};
      if (angle_sum >= 10'd720)      angle_in = 9'(angle_sum - 10'd720);
      else if (angle_sum >= 10'd360) angle_in = 9'(angle_sum - 10'd360);
      else                           angle_in = angle_sum[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= 8'(TEXTURE_SIDE);
         tex_height_ff <= 8'(TEXTURE_SIDE);
         angle_step_ff <= rtf_pkg::ANGLE_STEP_RESET;
         angle_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rtf_pkg::CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata[7:0];
               rtf_pkg::CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata[7:0];
               rtf_pkg::CSR_ANGLE_STEP: angle_step_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_acc && (req_data.operation == rtf_pkg::OP_ADVANCE)) angle_ff <= angle_in;
      end
   end

   rtf_coord_unit u_coord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && (is_load || is_render)),
      .in_ready  (req_ready),
      .in_side   (in_side),
      .angle     (angle_ff),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_data  (c_data)
   );

   rtf_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ready  (c_ready),
      .in_data   (c_data),
      .div       (div),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_data  (r_data)
   );

   rtf_texel_mem #(
      .TEXTURE_SIDE (TEXTURE_SIDE)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .in_data   (r_data),
      .div       (div),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/rtf_checker.sv =====
// Port-level checks on the rotozoom texel fetch core, bound to the top level.
`timescale 1ns / 1ps

module rtf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rtf_pkg::rsp_type rsp_data
);

   // a waiting result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with the result stage empty every stage can move, so input is taken
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   // off-screen coordinates never produce a result
   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.out_x) < rtf_pkg::DISPLAY_W)
                    && (32'(rsp_data.out_y) < rtf_pkg::DISPLAY_H))
      else $error("result for off-screen coordinate");

endmodule

bind rotozoom_texel_fetch_core rtf_checker u_checker (.*);
